// ----- rtl/rhsc_pkg.sv -----
package rhsc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MODE_W = 5;
    localparam int unsigned CLK_W  = 11;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned ADDR_W = 5;

    // register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_RANGE_LOW  = 3'd1;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd2;
    localparam logic [2:0] REG_OFF_DUR    = 3'd3;
    localparam logic [2:0] REG_ON_DUR     = 3'd4;
    localparam logic [2:0] REG_CLOCK_LOW  = 3'd5;
    localparam logic [2:0] REG_CLOCK_HIGH = 3'd6;

    // time select codes
    localparam logic [1:0] TSEL_NONE        = 2'd0;
    localparam logic [1:0] TSEL_HOUR        = 2'd1;
    localparam logic [1:0] TSEL_MINUTE      = 2'd2;
    localparam logic [1:0] TSEL_HOUR_MINUTE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] range_low;
        logic signed [DATA_W-1:0] range_high;
        logic [DATA_W-1:0]        off_duration;
        logic [DATA_W-1:0]        on_duration;
        logic [CLK_W-1:0]         clock_low;
        logic [CLK_W-1:0]         clock_high;
    } t_cfg;

    typedef struct packed {
        logic                     message_ok;
        logic                     value_present;
        logic signed [DATA_W-1:0] measurement;
        logic [HOUR_W-1:0]        hour_now;
        logic [MIN_W-1:0]         minute_now;
        logic [DATA_W-1:0]        now_ms;
    } t_item;

    typedef struct packed {
        logic              relay;
        logic              active;
        logic [DATA_W-1:0] on_start;
        logic [DATA_W-1:0] off_start;
        logic              failsafe;
    } t_state;

endpackage

// ----- rtl/rhsc_if.sv -----
interface rhsc_smp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 message_ok;
    logic                                 value_present;
    logic signed [rhsc_pkg::DATA_W-1:0]   measurement;
    logic [rhsc_pkg::HOUR_W-1:0]          hour_now;
    logic [rhsc_pkg::MIN_W-1:0]           minute_now;
    logic [rhsc_pkg::DATA_W-1:0]          now_ms;

    modport source (
        output valid, message_ok, value_present, measurement, hour_now, minute_now,
               now_ms,
        input  ready
    );
    modport sink (
        input  valid, message_ok, value_present, measurement, hour_now, minute_now,
               now_ms,
        output ready
    );
endinterface

interface rhsc_res_if;
    logic valid;
    logic ready;
    logic relay_level;
    logic active_now;
    logic failsafe_now;

    modport source (
        output valid, relay_level, active_now, failsafe_now,
        input  ready
    );
    modport sink (
        input  valid, relay_level, active_now, failsafe_now,
        output ready
    );
endinterface

// ----- rtl/rhsc_regs.sv -----
module rhsc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rhsc_pkg::DATA_W-1:0]   pwdata,
    output logic [rhsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rhsc_pkg::t_cfg                o_cfg,
    output logic                          o_mode_wr
);

    rhsc_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_idx     = paddr[4:2];
    assign o_cfg     = r_cfg;
    assign o_mode_wr = w_wr && (w_idx == rhsc_pkg::REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                rhsc_pkg::REG_MODE:       r_cfg.mode         <= pwdata[rhsc_pkg::MODE_W-1:0];
                rhsc_pkg::REG_RANGE_LOW:  r_cfg.range_low    <= pwdata;
                rhsc_pkg::REG_RANGE_HIGH: r_cfg.range_high   <= pwdata;
                rhsc_pkg::REG_OFF_DUR:    r_cfg.off_duration <= pwdata;
                rhsc_pkg::REG_ON_DUR:     r_cfg.on_duration  <= pwdata;
                rhsc_pkg::REG_CLOCK_LOW:  r_cfg.clock_low    <= pwdata[rhsc_pkg::CLK_W-1:0];
                rhsc_pkg::REG_CLOCK_HIGH: r_cfg.clock_high   <= pwdata[rhsc_pkg::CLK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rhsc_pkg::REG_MODE:
                prdata = {{(rhsc_pkg::DATA_W-rhsc_pkg::MODE_W){1'b0}}, r_cfg.mode};
            rhsc_pkg::REG_RANGE_LOW:  prdata = r_cfg.range_low;
            rhsc_pkg::REG_RANGE_HIGH: prdata = r_cfg.range_high;
            rhsc_pkg::REG_OFF_DUR:    prdata = r_cfg.off_duration;
            rhsc_pkg::REG_ON_DUR:     prdata = r_cfg.on_duration;
            rhsc_pkg::REG_CLOCK_LOW:
                prdata = {{(rhsc_pkg::DATA_W-rhsc_pkg::CLK_W){1'b0}}, r_cfg.clock_low};
            rhsc_pkg::REG_CLOCK_HIGH:
                prdata = {{(rhsc_pkg::DATA_W-rhsc_pkg::CLK_W){1'b0}}, r_cfg.clock_high};
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- rtl/rhsc_step.sv -----
module rhsc_step (
    input  rhsc_pkg::t_cfg   i_cfg,
    input  rhsc_pkg::t_item  i_item,
    input  rhsc_pkg::t_state i_state,
    output rhsc_pkg::t_state o_state
);

    logic                          w_timed;
    logic                          w_inv;
    logic [1:0]                    w_tsel;
    logic                          w_gated;
    logic                          w_lt_low;
    logic                          w_le_low;
    logic                          w_gt_high;
    logic                          w_ge_high;
    logic [rhsc_pkg::HOUR_W-1:0]   w_hl;
    logic [rhsc_pkg::HOUR_W-1:0]   w_hh;
    logic [rhsc_pkg::MIN_W-1:0]    w_ml;
    logic [rhsc_pkg::MIN_W-1:0]    w_mh;
    logic [rhsc_pkg::HOUR_W-1:0]   w_hr;
    logic [rhsc_pkg::MIN_W-1:0]    w_mn;
    logic [rhsc_pkg::DATA_W-1:0]   w_off_elapsed;
    logic [rhsc_pkg::DATA_W-1:0]   w_on_elapsed;
    logic                          w_fs;
    logic                          w_off_window;
    logic                          w_hm_off_lvl;
    logic                          w_hm_on_lvl;

    assign w_timed   = i_cfg.mode[1];
    assign w_inv     = i_cfg.mode[2];
    assign w_tsel    = i_cfg.mode[4:3];
    assign w_gated   = i_item.value_present;
    assign w_lt_low  = i_item.measurement <  i_cfg.range_low;
    assign w_le_low  = i_item.measurement <= i_cfg.range_low;
    assign w_gt_high = i_item.measurement >  i_cfg.range_high;
    assign w_ge_high = i_item.measurement >= i_cfg.range_high;
    assign w_hl      = i_cfg.clock_low[10:6];
    assign w_hh      = i_cfg.clock_high[10:6];
    assign w_ml      = i_cfg.clock_low[5:0];
    assign w_mh      = i_cfg.clock_high[5:0];
    assign w_hr      = i_item.hour_now;
    assign w_mn      = i_item.minute_now;

    assign w_off_elapsed = i_item.now_ms - i_state.off_start;
    assign w_on_elapsed  = i_item.now_ms - i_state.on_start;

    // failsafe latch update for the gated hour window
    always_comb begin
        w_fs = i_state.failsafe;
        if (w_gated) begin
            if (w_le_low && i_state.failsafe) begin
                w_fs = 1'b0;
            end else if (w_ge_high && !i_state.failsafe) begin
                w_fs = 1'b1;
            end
        end
        if (w_hh < w_hl) begin
            w_off_window = (w_hr >= w_hl) || (w_hr < w_hh);
        end else begin
            w_off_window = (w_hr >= w_hl) && (w_hr < w_hh);
        end
        if (w_gated && w_fs) begin
            w_off_window = 1'b1;
        end
    end

    assign w_hm_off_lvl = w_gated ? !w_ge_high : 1'b0;
    assign w_hm_on_lvl  = w_gated ? w_lt_low : 1'b1;

    always_comb begin
        o_state = i_state;
        if (i_item.message_ok) begin
            if (i_state.active) begin
                if (!w_timed) begin
                    if (w_lt_low) begin
                        o_state.relay = !w_inv;
                    end else if (w_gt_high) begin
                        o_state.relay = w_inv;
                    end
                end else begin
                    case (w_tsel)
                        rhsc_pkg::TSEL_HOUR: begin
                            o_state.failsafe = w_fs;
                            o_state.relay    = w_off_window ? w_inv : !w_inv;
                        end
                        rhsc_pkg::TSEL_MINUTE: begin
                            if (w_mn <= w_ml) begin
                                o_state.relay = w_gated ? !w_gt_high : 1'b0;
                            end else if (w_mn >= w_mh) begin
                                o_state.relay = w_gated ? w_lt_low : 1'b1;
                            end
                        end
                        rhsc_pkg::TSEL_HOUR_MINUTE: begin
                            if (w_hr == w_hl) begin
                                if (w_mn >= w_ml) begin
                                    o_state.relay = w_hm_off_lvl;
                                end
                            end else if (w_hr > w_hl) begin
                                o_state.relay = w_hm_off_lvl;
                            end else if (w_hr == w_hh) begin
                                if (w_mn >= w_mh) begin
                                    o_state.relay = w_hm_on_lvl;
                                end
                            end else if (w_hr > w_hh) begin
                                o_state.relay = w_hm_on_lvl;
                            end
                        end
                        default: begin
                            if (w_off_elapsed >= i_cfg.off_duration) begin
                                if (!w_gated || w_lt_low) begin
                                    o_state.relay    = 1'b1;
                                    o_state.active   = 1'b1;
                                    o_state.on_start = i_item.now_ms;
                                end else begin
                                    o_state.relay = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end else if (w_timed) begin
                if (w_on_elapsed >= i_cfg.on_duration) begin
                    if (!w_gated || w_ge_high) begin
                        o_state.relay     = 1'b0;
                        o_state.active    = 1'b0;
                        o_state.off_start = i_item.now_ms;
                    end else begin
                        o_state.relay = 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/relay_hysteresis_schedule_controller_core.sv -----
// Relay controller with hysteresis, duty timer and hour/minute schedules. Each
// sample transaction yields exactly one result transaction carrying the relay
// level, the active flag and the failsafe latch after that sample. A sample sits
// in the input register while the rule logic updates the state, and its result
// is loaded into the output register together with the new state, where it waits
// until it is taken. One sample is taken every cycle while results are taken; the
// state register feeds back through the rule logic. Registers are to be written
// over the APB port only while no sample is in flight; the block does not enforce
// this. Writing mode reloads the active flag from its enable bit.
module relay_hysteresis_schedule_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rhsc_smp_if.sink                      i_smp,
    rhsc_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rhsc_pkg::DATA_W-1:0]   pwdata,
    output logic [rhsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    rhsc_pkg::t_cfg   w_cfg;
    logic             w_mode_wr;
    rhsc_pkg::t_item  r_item;
    logic             r_in_vld;
    logic             r_out_vld;
    rhsc_pkg::t_state r_state;
    rhsc_pkg::t_state n_state;
    logic             w_in_acc;
    logic             w_out_load;
    logic             r_relay;
    logic             r_active;
    logic             r_failsafe;

    rhsc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_mode_wr (w_mode_wr)
    );

    rhsc_step u_step (
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state)
    );

    assign w_out_load  = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_smp.ready = !r_in_vld || w_out_load;
    assign w_in_acc    = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_out_load) begin
                r_in_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.message_ok    <= i_smp.message_ok;
            r_item.value_present <= i_smp.value_present;
            r_item.measurement   <= i_smp.measurement;
            r_item.hour_now      <= i_smp.hour_now;
            r_item.minute_now    <= i_smp.minute_now;
            r_item.now_ms        <= i_smp.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_mode_wr) begin
            r_state.active <= pwdata[0];
        end else if (w_out_load) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_relay    <= n_state.relay;
            r_active   <= n_state.active;
            r_failsafe <= n_state.failsafe;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.relay_level  = r_relay;
    assign o_res.active_now   = r_active;
    assign o_res.failsafe_now = r_failsafe;

endmodule
